// ===== design/bblc_pkg.sv =====
package bblc_pkg;
   localparam int ENTRIES = 16;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int TAG_W = 128;
   localparam int REC_W = TAG_W + 32 + 64;

   typedef enum logic [1:0] {
      FUNC_ACCESS  = 2'd0,
      FUNC_ERASE   = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_ENFORCE = 2'd3
   } func_type;

   typedef struct packed {
      logic [31:0] doc;
      logic [31:0] mesh;
      logic [63:0] rest;
      logic [31:0] size;
      logic [63:0] stamp;
   } rec_type;
endpackage

// ===== design/bblc_ram.sv =====
module bblc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/byte_budget_lru_cache.sv =====
// Byte-budgeted LRU tag store. One request word gives one response word. Slot
// records sit in a single-port-read RAM and are scanned one slot per cycle. An
// access scans for its key, then scans for the oldest stamp once per eviction,
// and a stamp wrap adds one more scan. Erase is a single scan, and enforce
// scans once per eviction. A new request word is taken in the cycle after the
// response word is accepted.
// The budget register is sampled when a word runs; func 3 re-applies it.
// Stamp wrap rewrites all valid stamps in one pass.
module byte_budget_lru_cache (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_func,
   input  logic [31:0]               req_doc_id,
   input  logic [31:0]               req_mesh_id,
   input  logic [63:0]               req_key_rest,
   input  logic                      req_key_ok,
   input  logic                      req_eval_ok,
   input  logic [31:0]               req_size_bytes,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic                      rsp_retained,
   output logic                      rsp_failed,
   output logic [4:0]                rsp_evicted_now,
   output logic [4:0]                rsp_entries_used,
   output logic [31:0]               rsp_retained_total,
   output logic [63:0]               rsp_hit_total,
   output logic [63:0]               rsp_miss_total,
   output logic [63:0]               rsp_evict_total,
   input  logic                      csr_wr_en,
   input  logic [31:0]               csr_wr_data
);
   import bblc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_DECIDE, S_OLD, S_DROP, S_INSERT, S_WRAP, S_ERASE,
      S_DONE, S_OUT
   } state_type;

   // Which check S_DECIDE runs after a lookup scan or an eviction.
   typedef enum logic [1:0] {
      G_ENFORCE, G_MISS, G_FULL
   } goal_type;

   state_type        state_ff;
   goal_type         goal_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [31:0]      budget_ff;
   logic [63:0]      serial_ff, hits_ff, miss_ff, evict_ff;
   logic [31:0]      held_ff;
   logic [1:0]       func_ff;
   logic [31:0]      doc_ff, mesh_ff, size_ff;
   logic [63:0]      rest_ff;
   logic             eval_ff;
   logic [IDX_W:0]   scan_ff;
   logic             found_ff;
   logic [IDX_W-1:0] at_ff;
   logic [63:0]      best_st_ff;
   logic [31:0]      best_sz_ff;
   logic             wrap_hit_ff;
   logic [4:0]       evn_ff;
   logic             hit_ff, ret_ff, fail_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   rec_type          wr_rec, rd_rec;
   logic [REC_W-1:0] rd_bits;
   logic [CNT_W-1:0] nvalid;
   logic [IDX_W-1:0] free_idx;
   logic [IDX_W-1:0] prev_idx;
   logic             prev_ok;
   logic [31:0]      held_sub;

   assign rd_rec = rec_type'(rd_bits);

   bblc_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(REC_W'(wr_rec)),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   always_comb begin
      nvalid = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         nvalid = nvalid + CNT_W'(valid_ff[i]);
      end
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // Slot whose read data arrives this cycle.
   assign prev_idx = IDX_W'(scan_ff - 1'b1);
   assign prev_ok  = (scan_ff != '0);
   assign rd_addr  = scan_ff[IDX_W-1:0];
   assign held_sub = (best_sz_ff <= held_ff) ? held_ff - best_sz_ff : 32'd0;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = at_ff;
      wr_rec  = rd_rec;
      if (state_ff == S_WRAP && prev_ok && valid_ff[prev_idx]) begin
         wr_en   = 1'b1;
         wr_addr = prev_idx;
         wr_rec.stamp = (wrap_hit_ff && prev_idx == at_ff) ? 64'd1 : 64'd0;
      end else if (state_ff == S_INSERT) begin
         wr_en        = 1'b1;
         wr_rec.doc   = doc_ff;
         wr_rec.mesh  = mesh_ff;
         wr_rec.rest  = rest_ff;
         wr_rec.size  = size_ff;
         wr_rec.stamp = serial_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_hit = hit_ff;
   assign rsp_retained = ret_ff;
   assign rsp_failed = fail_ff;
   assign rsp_evicted_now = evn_ff;
   assign rsp_entries_used = 5'(nvalid);
   assign rsp_retained_total = held_ff;
   assign rsp_hit_total = hits_ff;
   assign rsp_miss_total = miss_ff;
   assign rsp_evict_total = evict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
      end else if (csr_wr_en) begin
         budget_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         goal_ff  <= G_ENFORCE;
         valid_ff <= '0;
         serial_ff <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
         evict_ff <= '0;
         held_ff <= '0;
         scan_ff <= '0;
         found_ff <= 1'b0;
         wrap_hit_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff <= req_func;
                  doc_ff <= req_doc_id;
                  mesh_ff <= req_mesh_id;
                  rest_ff <= req_key_rest;
                  eval_ff <= req_eval_ok;
                  size_ff <= req_size_bytes;
                  hit_ff <= 1'b0;
                  ret_ff <= 1'b0;
                  fail_ff <= (func_type'(req_func) == FUNC_ACCESS) && !req_key_ok;
                  evn_ff <= '0;
                  scan_ff <= '0;
                  found_ff <= 1'b0;
                  case (func_type'(req_func))
                     FUNC_ACCESS: begin
                        if (!req_key_ok) begin
                           state_ff <= S_OUT;
                        end else begin
                           state_ff <= S_LOOK;
                        end
                     end
                     FUNC_ERASE: state_ff <= S_ERASE;
                     FUNC_CLEAR: begin
                        valid_ff <= '0;
                        held_ff <= '0;
                        state_ff <= S_OUT;
                     end
                     default: begin
                        goal_ff <= G_ENFORCE;
                        state_ff <= S_DECIDE;
                     end
                  endcase
               end
            end
            S_LOOK: begin
               if (prev_ok && !found_ff && valid_ff[prev_idx] &&
                   rd_rec.doc == doc_ff && rd_rec.mesh == mesh_ff &&
                   rd_rec.rest == rest_ff) begin
                  found_ff <= 1'b1;
                  at_ff <= prev_idx;
                  size_ff <= rd_rec.size;
               end
               if (scan_ff == (IDX_W+1)'(ENTRIES)) begin
                  state_ff <= S_DECIDE;
                  goal_ff <= G_MISS;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_DECIDE: begin
               scan_ff <= '0;
               found_ff <= 1'b0;
               if (func_ff == FUNC_ENFORCE) begin
                  state_ff <= (held_ff > budget_ff && valid_ff != '0) ? S_OLD : S_DONE;
               end else if (goal_ff == G_MISS && found_ff) begin
                  // Hit: restamp the matching slot.
                  hits_ff <= hits_ff + 64'd1;
                  hit_ff <= 1'b1;
                  ret_ff <= 1'b1;
                  if (serial_ff == '1) begin
                     serial_ff <= 64'd1;
                     wrap_hit_ff <= 1'b1;
                     state_ff <= S_WRAP;
                  end else begin
                     serial_ff <= serial_ff + 64'd1;
                     state_ff <= S_INSERT;
                  end
               end else if (goal_ff == G_MISS) begin
                  miss_ff <= miss_ff + 64'd1;
                  if (!eval_ff) begin
                     fail_ff <= 1'b1;
                     state_ff <= S_DONE;
                  end else if (budget_ff == '0 || size_ff > budget_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     goal_ff <= G_FULL;
                     state_ff <= (held_ff > budget_ff - size_ff && valid_ff != '0)
                                 ? S_OLD : S_DECIDE;
                  end
               end else begin
                  // Make room while the budget is short or the table is full, then insert.
                  if (held_ff > budget_ff - size_ff && valid_ff != '0) begin
                     state_ff <= S_OLD;
                  end else if (nvalid >= CNT_W'(ENTRIES) && !wrap_hit_ff) begin
                     wrap_hit_ff <= 1'b1;
                     state_ff <= S_OLD;
                  end else begin
                     wrap_hit_ff <= 1'b0;
                     at_ff <= free_idx;
                     ret_ff <= 1'b1;
                     held_ff <= held_ff + size_ff;
                     valid_ff[free_idx] <= 1'b1;
                     if (serial_ff == '1) begin
                        serial_ff <= 64'd1;
                        state_ff <= S_WRAP;
                     end else begin
                        serial_ff <= serial_ff + 64'd1;
                        state_ff <= S_INSERT;
                     end
                  end
               end
            end
            S_OLD: begin
               if (prev_ok && valid_ff[prev_idx] &&
                   (!found_ff || rd_rec.stamp < best_st_ff)) begin
                  found_ff <= 1'b1;
                  at_ff <= prev_idx;
                  best_st_ff <= rd_rec.stamp;
                  best_sz_ff <= rd_rec.size;
               end
               if (scan_ff == (IDX_W+1)'(ENTRIES)) begin
                  state_ff <= S_DROP;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_DROP: begin
               held_ff <= held_sub;
               valid_ff[at_ff] <= 1'b0;
               evict_ff <= evict_ff + 64'd1;
               evn_ff <= evn_ff + 5'd1;
               state_ff <= S_DECIDE;
            end
            S_WRAP: begin
               if (scan_ff == (IDX_W+1)'(ENTRIES)) begin
                  if (wrap_hit_ff) begin
                     wrap_hit_ff <= 1'b0;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_INSERT;
                  end
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_INSERT: state_ff <= S_DONE;
            S_ERASE: begin
               if (prev_ok && valid_ff[prev_idx] &&
                   rd_rec.doc == doc_ff && rd_rec.mesh == mesh_ff) begin
                  valid_ff[prev_idx] <= 1'b0;
                  held_ff <= (rd_rec.size <= held_ff) ? held_ff - rd_rec.size : 32'd0;
               end
               if (scan_ff == (IDX_W+1)'(ENTRIES)) begin
                  state_ff <= S_DONE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_DONE: state_ff <= S_OUT;
            S_OUT: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request and response overlap");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == FUNC_CLEAR) |=> (valid_ff == '0))
      else $error("clear left entries");
   a_hit_ret: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_retained && !rsp_failed)
      else $error("hit not retained");
endmodule
